// ===== rtl/core/hts_pkg.sv =====
package hts_pkg;

    // Mode codes
    localparam logic [2:0] MODE_IDLE   = 3'd0;
    localparam logic [2:0] MODE_HEAT   = 3'd1;
    localparam logic [2:0] MODE_STAB   = 3'd2;
    localparam logic [2:0] MODE_TARGET = 3'd3;
    localparam logic [2:0] MODE_OVER   = 3'd4;

    // Config register indexes
    localparam logic [2:0] REG_COLD_BELOW     = 3'd0;
    localparam logic [2:0] REG_BAND_LOW       = 3'd1;
    localparam logic [2:0] REG_BAND_HIGH      = 3'd2;
    localparam logic [2:0] REG_OVERHEAT_ABOVE = 3'd3;
    localparam logic [2:0] REG_COOL_BELOW     = 3'd4;
    localparam logic [2:0] REG_HOLD_MS        = 3'd5;
    localparam logic [2:0] REG_BLINK_HALF_MS  = 3'd6;

    // Reset values of the thresholds (raw codes, 4095 = 50 deg)
    localparam logic [11:0] RST_COLD_BELOW     = 12'd1638;
    localparam logic [11:0] RST_BAND_LOW       = 12'd1843;
    localparam logic [11:0] RST_BAND_HIGH      = 12'd1924;
    localparam logic [11:0] RST_OVERHEAT_ABOVE = 12'd2293;
    localparam logic [11:0] RST_COOL_BELOW     = 12'd1884;
    localparam logic [15:0] RST_HOLD_MS        = 16'd5000;
    localparam logic [15:0] RST_BLINK_HALF_MS  = 16'd250;

    typedef struct packed {
        logic [11:0] cold_below;
        logic [11:0] band_low;
        logic [11:0] band_high;
        logic [11:0] overheat_above;
        logic [11:0] cool_below;
        logic [15:0] hold_ms;
        logic [15:0] blink_half_ms;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  mode;
        logic        hold_running;
        logic [15:0] hold_elapsed;
        logic [15:0] blink_elapsed;
        logic        blink_level;
    } t_state;

    typedef struct packed {
        logic [11:0] temp_code;
        logic [15:0] elapsed_ms;
    } t_item;

    typedef struct packed {
        logic [2:0] mode;
        logic       heater_on;
        logic       led_on;
        logic       buzzer_on;
        logic       mode_changed;
    } t_result;

    // Saturating 16-bit add
    function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            sat_add16 = s[16] ? 16'hFFFF : s[15:0];
        end
    endfunction

endpackage

// ===== rtl/core/heater_thermostat_fsm_core.sv =====
// Heater thermostat core. Each input transaction carries one raw 12-bit
// temperature code (0..4095 spans 0..50 deg) and the milliseconds since the
// previous transaction; each produces exactly one output transaction with
// the mode after that sample (0 idle, 1 heating, 2 stabilizing, 3 target
// reached, 4 overheat), heater, LED and buzzer drives, and a mode-changed
// flag. Target is reached only after the sample stays in band for longer
// than hold_ms; the hold timer restarts on each entry to stabilizing. In
// overheat the LED toggles each time more than blink_half_ms has built up.
// Both timers saturate at 65535. A transaction accepted into the input
// register is stepped into the result register, which also updates the
// machine state, once that register is empty or being drained. Throughput
// is one transaction per cycle while the result side does not stall,
// limited only by the single next-state step between those registers. The
// input side keeps accepting while a result waits, up to one item held in
// the input register. Thresholds are written through
// i_cfg_we/i_cfg_index/i_cfg_data (indexes 0..6 as listed in the package,
// others ignored); the user must write them only while the block is idle,
// which the block itself does not enforce. They reset to the nominal 20.0 /
// 22.5 / 23.5 / 28.0 / 23.0 deg codes, 5000 ms and 250 ms.
module heater_thermostat_fsm_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write port
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // sample channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [11:0] i_temp_code,
    input  logic [15:0] i_elapsed_ms,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_mode,
    output logic        o_heater_on,
    output logic        o_led_on,
    output logic        o_buzzer_on,
    output logic        o_mode_changed
);

    hts_pkg::t_cfg    r_cfg;
    hts_pkg::t_state  r_state;
    hts_pkg::t_state  n_state;
    hts_pkg::t_result r_result;
    hts_pkg::t_result n_result;
    hts_pkg::t_item   w_item;
    logic             w_item_valid;
    logic             w_take;
    logic             r_out_valid;

    // Config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cold_below     <= hts_pkg::RST_COLD_BELOW;
            r_cfg.band_low       <= hts_pkg::RST_BAND_LOW;
            r_cfg.band_high      <= hts_pkg::RST_BAND_HIGH;
            r_cfg.overheat_above <= hts_pkg::RST_OVERHEAT_ABOVE;
            r_cfg.cool_below     <= hts_pkg::RST_COOL_BELOW;
            r_cfg.hold_ms        <= hts_pkg::RST_HOLD_MS;
            r_cfg.blink_half_ms  <= hts_pkg::RST_BLINK_HALF_MS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                hts_pkg::REG_COLD_BELOW:     r_cfg.cold_below     <= i_cfg_data[11:0];
                hts_pkg::REG_BAND_LOW:       r_cfg.band_low       <= i_cfg_data[11:0];
                hts_pkg::REG_BAND_HIGH:      r_cfg.band_high      <= i_cfg_data[11:0];
                hts_pkg::REG_OVERHEAT_ABOVE: r_cfg.overheat_above <= i_cfg_data[11:0];
                hts_pkg::REG_COOL_BELOW:     r_cfg.cool_below     <= i_cfg_data[11:0];
                hts_pkg::REG_HOLD_MS:        r_cfg.hold_ms        <= i_cfg_data;
                hts_pkg::REG_BLINK_HALF_MS:  r_cfg.blink_half_ms  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Stage 1: sample register
    hts_in_reg u_in_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_temp_code  (i_temp_code),
        .i_elapsed_ms (i_elapsed_ms),
        .i_take       (w_take),
        .o_valid      (w_item_valid),
        .o_item       (w_item)
    );

    // Stage 2 advances when the result register is empty or being drained
    assign w_take = w_item_valid && (!r_out_valid || i_out_ready);

    hts_step u_step (
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .i_item   (w_item),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // Machine state commits together with the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode          <= hts_pkg::MODE_IDLE;
            r_state.hold_running  <= 1'b0;
            r_state.hold_elapsed  <= 16'd0;
            r_state.blink_elapsed <= 16'd0;
            r_state.blink_level   <= 1'b0;
        end else if (w_take) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_mode         = r_result.mode;
    assign o_heater_on    = r_result.heater_on;
    assign o_led_on       = r_result.led_on;
    assign o_buzzer_on    = r_result.buzzer_on;
    assign o_mode_changed = r_result.mode_changed;

    // Hold timer only lives in stabilizing
    a_hold_in_stab: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.hold_running |-> (r_state.mode == hts_pkg::MODE_STAB))
        else $error("hold timer running outside stabilizing");

    a_hold_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_state.hold_running |-> (r_state.hold_elapsed == 16'd0))
        else $error("hold timer not cleared when stopped");

    // Blink level only set in overheat
    a_blink_in_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.blink_level |-> (r_state.mode == hts_pkg::MODE_OVER))
        else $error("blink level set outside overheat");

    // A stalled result must not be overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !w_take)
        else $error("result register overwritten while stalled");

    // Result register mode tracks the committed state
    a_result_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |=> (r_result.mode == r_state.mode))
        else $error("result mode disagrees with state");

endmodule

// ===== rtl/core/hts_in_reg.sv =====
// Input register: holds one transaction until the step logic consumes it.
module hts_in_reg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic [11:0]     i_temp_code,
    input  logic [15:0]     i_elapsed_ms,
    input  logic            i_take,
    output logic            o_valid,
    output hts_pkg::t_item  o_item
);

    logic           r_valid;
    hts_pkg::t_item r_item;
    logic           w_load;

    assign o_in_ready = !r_valid || i_take;
    assign w_load     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item.temp_code  <= i_temp_code;
            r_item.elapsed_ms <= i_elapsed_ms;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== rtl/core/hts_step.sv =====
// Next-state and output logic for one sample.
module hts_step (
    input  hts_pkg::t_cfg    i_cfg,
    input  hts_pkg::t_state  i_state,
    input  hts_pkg::t_item   i_item,
    output hts_pkg::t_state  o_state,
    output hts_pkg::t_result o_result
);

    logic [11:0] w_t;
    logic [15:0] w_dt;
    logic        w_cold, w_hot, w_in_band;
    logic [15:0] w_hold;
    logic [15:0] w_blink;
    logic [2:0]  w_nxt;
    logic        w_stay_stab;
    logic        w_toggle;

    assign w_t       = i_item.temp_code;
    assign w_dt      = i_item.elapsed_ms;
    assign w_cold    = w_t < i_cfg.cold_below;
    assign w_hot     = w_t > i_cfg.overheat_above;
    assign w_in_band = (w_t >= i_cfg.band_low) && (w_t <= i_cfg.band_high);

    // Hold timer restarts at zero on the first in-band sample
    assign w_hold = i_state.hold_running ?
                    hts_pkg::sat_add16(i_state.hold_elapsed, w_dt) : 16'd0;

    always_comb begin
        w_nxt = i_state.mode;
        unique case (i_state.mode)
            hts_pkg::MODE_HEAT: begin
                if (w_t >= i_cfg.band_low) w_nxt = hts_pkg::MODE_STAB;
                else if (w_hot)            w_nxt = hts_pkg::MODE_OVER;
            end
            hts_pkg::MODE_STAB: begin
                if (w_in_band) begin
                    if (w_hold > i_cfg.hold_ms) w_nxt = hts_pkg::MODE_TARGET;
                end else if (w_cold) begin
                    w_nxt = hts_pkg::MODE_HEAT;
                end else if (w_hot) begin
                    w_nxt = hts_pkg::MODE_OVER;
                end
            end
            hts_pkg::MODE_TARGET: begin
                if (w_t < i_cfg.band_low) w_nxt = hts_pkg::MODE_HEAT;
                else if (w_hot)           w_nxt = hts_pkg::MODE_OVER;
            end
            hts_pkg::MODE_OVER: begin
                if (w_t < i_cfg.cool_below) w_nxt = hts_pkg::MODE_IDLE;
            end
            default: begin
                // idle, and any stray code
                if (w_cold)     w_nxt = hts_pkg::MODE_HEAT;
                else if (w_hot) w_nxt = hts_pkg::MODE_OVER;
            end
        endcase
    end

    assign w_stay_stab = (i_state.mode == hts_pkg::MODE_STAB) &&
                         (w_nxt == hts_pkg::MODE_STAB);

    assign w_blink  = hts_pkg::sat_add16(i_state.blink_elapsed, w_dt);
    assign w_toggle = (w_nxt == hts_pkg::MODE_OVER) && (w_blink > i_cfg.blink_half_ms);

    always_comb begin
        o_state.mode          = w_nxt;
        o_state.hold_running  = w_stay_stab && w_in_band;
        o_state.hold_elapsed  = (w_stay_stab && w_in_band) ? w_hold : 16'd0;
        o_state.blink_elapsed = w_toggle ? 16'd0 : w_blink;
        if (w_nxt == hts_pkg::MODE_OVER) begin
            o_state.blink_level = i_state.blink_level ^ w_toggle;
        end else begin
            o_state.blink_level = 1'b0;
        end
    end

    always_comb begin
        o_result.mode         = w_nxt;
        o_result.heater_on    = (w_nxt == hts_pkg::MODE_HEAT) ||
                                (w_nxt == hts_pkg::MODE_STAB);
        o_result.led_on       = (w_nxt == hts_pkg::MODE_OVER) ? o_state.blink_level :
                                (w_nxt == hts_pkg::MODE_TARGET);
        o_result.buzzer_on    = (w_nxt == hts_pkg::MODE_OVER);
        o_result.mode_changed = (w_nxt != i_state.mode);
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import hts_pkg::*;

    // Run control
    localparam int unsigned CYCLE_LIMIT     = 400000;
    localparam int unsigned DRAIN_CYCLES    = 8;     // drain margin after the last result
    localparam int unsigned HOLD_OFF_CYCLES = 400;   // long receiver stall, fills the core

    // Idle pattern of both channel sides, changed between phases
    typedef enum {PACE_FULL, PACE_SPARSE, PACE_RANDOM} t_pace;

    // Temperature windows relative to the programmed thresholds
    typedef enum {
        REGION_COLD, REGION_BAND, REGION_WARM, REGION_HOT, REGION_COOL, REGION_EDGE
    } t_region;

    // Directed opening run at reset thresholds: {temp_code, elapsed_ms}
    localparam logic [27:0] OPENING_RUN [0:25] = '{
        {12'd2000, 16'd0},      // idle, no trigger
        {12'd4095, 16'd65535},  // idle -> overheat, blink timer saturates and toggles
        {12'd2294, 16'd100},    // overheat holds, no toggle yet
        {12'd1884, 16'd200},    // exactly at cool limit: stays, toggle back
        {12'd1883, 16'd0},      // overheat -> idle
        {12'd0,    16'd1},      // idle -> heating at code zero
        {12'd1842, 16'd10},     // just below band floor
        {12'd1843, 16'd10},     // heating -> stabilizing
        {12'd1900, 16'd3000},   // hold timer starts at zero
        {12'd1900, 16'd3000},
        {12'd1925, 16'd50},     // slip above band: timer stops, mode stays
        {12'd1924, 16'd4000},   // back in band: timer restarts at zero
        {12'd1843, 16'd4000},
        {12'd1843, 16'd1000},   // exactly hold_ms: not yet
        {12'd1843, 16'd1},      // hold exceeded -> target
        {12'd2293, 16'd65535},  // at overheat limit, stays in target
        {12'd2294, 16'd0},      // target -> overheat
        {12'd1883, 16'd0},      // -> idle
        {12'd1637, 16'd0},      // -> heating
        {12'd4095, 16'd0},      // heating goes to stabilizing before overheat is tested
        {12'd1637, 16'd0},      // stabilizing -> heating on cold
        {12'd1900, 16'd0},      // -> stabilizing
        {12'd2293, 16'd0},      // warm but not hot: stays
        {12'd2294, 16'd0},      // stabilizing -> overheat
        {12'd0,    16'd65535},  // -> idle
        {12'd4095, 16'd0}       // idle -> overheat at full scale
    };

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_cfg_we       = 1'b0;
    logic [2:0]  i_cfg_index    = '0;
    logic [15:0] i_cfg_data     = '0;
    logic        i_in_valid     = 1'b0;
    logic        o_in_ready;
    logic [11:0] i_temp_code    = '0;
    logic [15:0] i_elapsed_ms   = '0;
    logic        o_out_valid;
    logic        i_out_ready    = 1'b0;
    logic [2:0]  o_mode;
    logic        o_heater_on;
    logic        o_led_on;
    logic        o_buzzer_on;
    logic        o_mode_changed;

    heater_thermostat_fsm_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_temp_code    (i_temp_code),
        .i_elapsed_ms   (i_elapsed_ms),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_mode         (o_mode),
        .o_heater_on    (o_heater_on),
        .o_led_on       (o_led_on),
        .o_buzzer_on    (o_buzzer_on),
        .o_mode_changed (o_mode_changed)
    );

    // Shadow of the thermostat: programmed limits and machine state
    t_cfg limits = {RST_COLD_BELOW, RST_BAND_LOW, RST_BAND_HIGH, RST_OVERHEAT_ABOVE,
                    RST_COOL_BELOW, RST_HOLD_MS, RST_BLINK_HALF_MS};
    t_state shadow = '0;

    t_item       sample_q[$];    // samples waiting to be sent
    t_result     due_results[$]; // predicted results, oldest first
    t_pace       pace         = PACE_FULL;
    int unsigned queued       = 0;
    int unsigned err_count    = 0;
    int unsigned results_seen = 0;
    int unsigned send_gap     = 0;
    int unsigned stall_left   = 0;
    int unsigned cycle_count  = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [15:0] add_clamped(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[16] ? 16'hFFFF : s[15:0];
    endfunction

    // Next thermostat result for one sample; advances the shadow state
    function automatic t_result thermo_next(input t_item smp);
        logic [2:0] cur;
        logic [2:0] nxt;
        logic       in_band;
        logic       led;
        t_result    r;
        cur = shadow.mode;
        nxt = cur;
        in_band = (smp.temp_code >= limits.band_low) && (smp.temp_code <= limits.band_high);
        case (cur)
            MODE_HEAT: begin
                if (smp.temp_code >= limits.band_low) nxt = MODE_STAB;
                else if (smp.temp_code > limits.overheat_above) nxt = MODE_OVER;
            end
            MODE_STAB: begin
                if (in_band) begin
                    if (!shadow.hold_running) begin
                        shadow.hold_running = 1'b1;
                        shadow.hold_elapsed = '0;
                    end else begin
                        shadow.hold_elapsed = add_clamped(shadow.hold_elapsed, smp.elapsed_ms);
                    end
                    if (shadow.hold_elapsed > limits.hold_ms) nxt = MODE_TARGET;
                end else begin
                    shadow.hold_running = 1'b0;
                    shadow.hold_elapsed = '0;
                    if (smp.temp_code < limits.cold_below) nxt = MODE_HEAT;
                    else if (smp.temp_code > limits.overheat_above) nxt = MODE_OVER;
                end
            end
            MODE_TARGET: begin
                if (smp.temp_code < limits.band_low) nxt = MODE_HEAT;
                else if (smp.temp_code > limits.overheat_above) nxt = MODE_OVER;
            end
            MODE_OVER: begin
                if (smp.temp_code < limits.cool_below) nxt = MODE_IDLE;
            end
            default: begin
                if (smp.temp_code < limits.cold_below) nxt = MODE_HEAT;
                else if (smp.temp_code > limits.overheat_above) nxt = MODE_OVER;
            end
        endcase
        // hold timer lives only within one stay in stabilizing
        if (nxt != MODE_STAB || cur != MODE_STAB) begin
            shadow.hold_running = 1'b0;
            shadow.hold_elapsed = '0;
        end
        // blink timer runs in every mode, toggles only in overheat
        shadow.blink_elapsed = add_clamped(shadow.blink_elapsed, smp.elapsed_ms);
        if (nxt == MODE_OVER) begin
            if (shadow.blink_elapsed > limits.blink_half_ms) begin
                shadow.blink_level   = ~shadow.blink_level;
                shadow.blink_elapsed = '0;
            end
            led = shadow.blink_level;
        end else begin
            shadow.blink_level = 1'b0;
            led = (nxt == MODE_TARGET);
        end
        shadow.mode    = nxt;
        r.mode         = nxt;
        r.heater_on    = (nxt == MODE_HEAT) || (nxt == MODE_STAB);
        r.led_on       = led;
        r.buzzer_on    = (nxt == MODE_OVER);
        r.mode_changed = (nxt != cur);
        return r;
    endfunction

    function automatic int unsigned draw_wait();
        case (pace)
            PACE_FULL:   return 0;
            PACE_SPARSE: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
            default:     return $urandom_range(0, 16);
        endcase
    endfunction

    // Random code inside a window; an empty window falls back to full scale
    function automatic logic [11:0] code_in(input t_region r);
        int lo;
        int hi;
        lo = 0;
        hi = 4095;
        case (r)
            REGION_COLD: hi = int'(limits.cold_below) - 1;
            REGION_BAND: begin
                lo = int'(limits.band_low);
                hi = int'(limits.band_high);
            end
            REGION_WARM: begin
                lo = int'(limits.band_high) + 1;
                hi = int'(limits.overheat_above);
            end
            REGION_HOT:  lo = int'(limits.overheat_above) + 1;
            REGION_COOL: hi = int'(limits.cool_below) - 1;
            default: begin
                // one code either side of a threshold, or on it
                case ($urandom_range(0, 4))
                    0:       lo = int'(limits.cold_below);
                    1:       lo = int'(limits.band_low);
                    2:       lo = int'(limits.band_high);
                    3:       lo = int'(limits.overheat_above);
                    default: lo = int'(limits.cool_below);
                endcase
                lo = lo + int'($urandom_range(0, 2)) - 1;
                if (lo < 0) lo = 0;
                if (lo > 4095) lo = 4095;
                hi = lo;
            end
        endcase
        if (lo > hi) return 12'($urandom);
        return 12'($urandom_range(hi, lo));
    endfunction

    function automatic logic [15:0] pick_elapsed();
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom);
            default: return 16'($urandom_range(0, 600));
        endcase
    endfunction

    function automatic logic [15:0] clamp16(input int unsigned v);
        return (v > 65535) ? 16'hFFFF : 16'(v);
    endfunction

    task automatic offer(input logic [11:0] code, input logic [15:0] ms);
        sample_q.push_back({code, ms});
        queued++;
    endtask

    // One heat-up cycle: cold dip, dwell in band, target, maybe an overheat
    // burst and cool-down, then some noise.
    task automatic add_episode();
        int unsigned dwell;
        int unsigned per;
        int unsigned n;
        dwell = $urandom_range(2, 7);
        per   = limits.hold_ms / (dwell - 1) + $urandom_range(0, 2);
        repeat ($urandom_range(1, 2)) offer(code_in(REGION_COLD), pick_elapsed());
        offer(code_in(REGION_BAND), pick_elapsed());
        repeat (dwell) begin
            // occasional slip out of band restarts the hold timer
            if ($urandom_range(0, 9) == 0) offer(code_in(REGION_WARM), pick_elapsed());
            offer(code_in(REGION_BAND), clamp16(per));
        end
        repeat ($urandom_range(0, 3)) begin
            offer(code_in($urandom_range(0, 1) ? REGION_BAND : REGION_EDGE), pick_elapsed());
        end
        if ($urandom_range(0, 1)) begin
            n = $urandom_range(1, 6);
            offer(code_in(REGION_HOT), pick_elapsed());
            repeat (n) begin
                offer(code_in($urandom_range(0, 2) ? REGION_HOT : REGION_WARM),
                      clamp16($urandom_range(0, limits.blink_half_ms + 2)));
            end
            offer(code_in(REGION_COOL), pick_elapsed());
        end
        repeat ($urandom_range(0, 2)) offer(12'($urandom), 16'($urandom));
    endtask

    // Returns once every sample is sent and every result is back. Polled on
    // the falling edge so the driver's updates from the rising edge are in.
    task automatic settle();
        while (sample_q.size() != 0 || i_in_valid || due_results.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        case (idx)
            REG_COLD_BELOW:     limits.cold_below     = val[11:0];
            REG_BAND_LOW:       limits.band_low       = val[11:0];
            REG_BAND_HIGH:      limits.band_high      = val[11:0];
            REG_OVERHEAT_ABOVE: limits.overheat_above = val[11:0];
            REG_COOL_BELOW:     limits.cool_below     = val[11:0];
            REG_HOLD_MS:        limits.hold_ms        = val;
            REG_BLINK_HALF_MS:  limits.blink_half_ms  = val;
            default: ;  // unmapped index, core ignores it
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Program all registers; junk in the upper nibble of the 12-bit ones
    task automatic program_limits(input t_cfg c);
        write_reg(REG_COLD_BELOW,     {4'($urandom), c.cold_below});
        write_reg(REG_BAND_LOW,       {4'($urandom), c.band_low});
        write_reg(REG_BAND_HIGH,      {4'($urandom), c.band_high});
        write_reg(REG_OVERHEAT_ABOVE, {4'($urandom), c.overheat_above});
        write_reg(REG_COOL_BELOW,     {4'($urandom), c.cool_below});
        write_reg(REG_HOLD_MS,        c.hold_ms);
        write_reg(REG_BLINK_HALF_MS,  c.blink_half_ms);
    endtask

    function automatic t_cfg ordered_limits(input int unsigned hold_max,
                                            input int unsigned blink_max);
        t_cfg c;
        c.cold_below     = 12'($urandom_range(200, 1800));
        c.band_low       = c.cold_below + 12'($urandom_range(0, 300));
        c.band_high      = c.band_low + 12'($urandom_range(0, 300));
        c.overheat_above = c.band_high + 12'($urandom_range(0, 600));
        c.cool_below     = 12'($urandom_range(c.overheat_above, c.band_low));
        c.hold_ms        = clamp16($urandom_range(0, hold_max));
        c.blink_half_ms  = clamp16($urandom_range(0, blink_max));
        return c;
    endfunction

    task automatic run_random(input t_pace p, input int unsigned budget);
        pace   = p;
        queued = 0;
        while (queued < budget) add_episode();
        settle();
    endtask

    // Sample driver: predicts on every accepted transaction, then launches
    // the next queued sample once its drawn gap has run out.
    always @(posedge i_clk) begin : sample_driver
        logic  nxt_valid;
        t_item nxt_item;
        nxt_valid = i_in_valid;
        nxt_item  = {i_temp_code, i_elapsed_ms};
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                due_results.push_back(thermo_next({i_temp_code, i_elapsed_ms}));
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (send_gap != 0) begin
                    send_gap--;
                end else if (sample_q.size() != 0) begin
                    nxt_item  = sample_q.pop_front();
                    nxt_valid = 1'b1;
                    send_gap  = draw_wait();
                end
            end
        end
        i_in_valid   <= nxt_valid;
        i_temp_code  <= nxt_item.temp_code;
        i_elapsed_ms <= nxt_item.elapsed_ms;
    end

    task automatic check_field(input string what, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            err_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        end
    endtask

    // Result monitor and receiver. After each transaction it draws a stall;
    // twice in the run it holds off long enough that the core backs up and
    // drops o_in_ready while samples are still offered.
    always @(posedge i_clk) begin : result_side
        t_result got;
        t_result want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                got = {o_mode, o_heater_on, o_led_on, o_buzzer_on, o_mode_changed};
                results_seen++;
                if (due_results.size() == 0) begin
                    err_count++;
                    $display("%0t: result transaction with nothing expected, actual mode %0d",
                             $time, got.mode);
                end else begin
                    want = due_results.pop_front();
                    check_field("mode",         want.mode,         got.mode);
                    check_field("heater_on",    want.heater_on,    got.heater_on);
                    check_field("led_on",       want.led_on,       got.led_on);
                    check_field("buzzer_on",    want.buzzer_on,    got.buzzer_on);
                    check_field("mode_changed", want.mode_changed, got.mode_changed);
                end
                stall_left = draw_wait();
                if (results_seen == 350 || results_seen == 900) stall_left = HOLD_OFF_CYCLES;
            end
            if (stall_left != 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    initial begin : sequencer
        t_cfg c;
        int   k;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed run at reset thresholds, back to back
        pace = PACE_FULL;
        for (k = 0; k < 26; k++) offer(OPENING_RUN[k][27:16], OPENING_RUN[k][15:0]);
        settle();

        // Reset values written back explicitly, plus an unmapped index
        c = {RST_COLD_BELOW, RST_BAND_LOW, RST_BAND_HIGH, RST_OVERHEAT_ABOVE,
             RST_COOL_BELOW, RST_HOLD_MS, RST_BLINK_HALF_MS};
        program_limits(c);
        write_reg(3'd7, 16'($urandom));
        run_random(PACE_RANDOM, 220);

        // Zero hold and blink times: target once the hold time in band is
        // nonzero, LED toggles on any elapsed time
        c = ordered_limits(0, 0);
        program_limits(c);
        run_random(PACE_SPARSE, 150);

        // Everything at full scale: nothing is ever hot, timers never expire
        c = {12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 16'hFFFF, 16'hFFFF};
        program_limits(c);
        run_random(PACE_FULL, 100);

        // Everything at zero: any nonzero code is hot, no way back from overheat
        c = '0;
        program_limits(c);
        run_random(PACE_RANDOM, 80);

        // Band above the overheat limit: heating can go straight to overheat
        c = {12'd1000, 12'd3000, 12'd3500, 12'd2000, 12'd1500, 16'd800, 16'd100};
        program_limits(c);
        run_random(PACE_RANDOM, 150);

        // Mixed ordered thresholds with moderate timers
        c = ordered_limits(3000, 400);
        program_limits(c);
        run_random(PACE_SPARSE, 150);
        c = ordered_limits(65535, 2000);
        program_limits(c);
        run_random(PACE_RANDOM, 150);

        if (err_count == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
